// ----- rtl/core/fcpr_pkg.sv -----
// ============================================================================
// fcpr_pkg
// Shared types, codes and helpers of the frame checksum port router.
// ============================================================================
`default_nettype none

package fcpr_pkg;

    localparam int unsigned SUM_W = 16;

    localparam logic [1:0] ACK_OK          = 2'd0;
    localparam logic [1:0] ACK_CSUM_ERR    = 2'd1;
    localparam logic [1:0] ACK_PORT_CLOSED = 2'd2;

    localparam logic [0:0] REG_OPEN_PORTS = 1'd0;

    typedef struct packed {
        logic [31:0] data_word;
        logic        last_word;
        logic [15:0] port;
        logic [15:0] msg_number;
        logic [15:0] received_checksum;
    } frame_item_t;

    typedef struct packed {
        logic [1:0]  ack_code;
        logic [15:0] computed_checksum;
        logic [15:0] forward_checksum;
        logic [15:0] dest_port;
    } result_item_t;

    // Sixteen-bit ones'-complement add with end-around carry.
    function automatic logic [SUM_W-1:0] oc_add(input logic [SUM_W-1:0] a,
                                                input logic [SUM_W-1:0] b);
        logic [SUM_W:0]   s;
        logic [SUM_W:0]   f;
        s = {1'b0, a} + {1'b0, b};
        f = {1'b0, s[SUM_W-1:0]} + {{SUM_W{1'b0}}, s[SUM_W]};
        return f[SUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/fcpr_in_reg.sv -----
// ============================================================================
// fcpr_in_reg
// Input register that holds one accepted frame word until it is consumed.
// ============================================================================
`default_nettype none

module fcpr_in_reg (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 frame_valid,
    output logic                      frame_ready,
    input  wire fcpr_pkg::frame_item_t frame,
    input  wire logic                 take,
    output logic                      hold_valid,
    output fcpr_pkg::frame_item_t     hold
);
    import fcpr_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    frame_item_t item_reg;

    assign frame_ready = !valid_reg || take;
    assign hold_valid  = valid_reg;
    assign hold        = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (frame_valid && frame_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_valid && frame_ready)
        begin
            item_reg <= frame;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/fcpr_check.sv -----
// ============================================================================
// fcpr_check
// Running payload sum, checksum verification and open-port lookup.
// ============================================================================
`default_nettype none

module fcpr_check #(
    parameter int unsigned PORTS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire fcpr_pkg::frame_item_t item,
    input  wire logic                  take,
    input  wire logic [15:0]           open_mask,
    output fcpr_pkg::result_item_t     result
);
    import fcpr_pkg::*;

    logic [SUM_W-1:0] payload_sum_reg;
    logic [SUM_W-1:0] payload_sum_next;
    logic [SUM_W-1:0] word_sum;
    logic [SUM_W-1:0] full_sum;
    logic [SUM_W-1:0] computed;
    logic [15:0]      port_idx;
    logic             in_range;
    logic             port_open;

    always_comb
    begin
        word_sum  = oc_add(oc_add(payload_sum_reg, item.data_word[15:0]),
                           item.data_word[31:16]);
        full_sum  = oc_add(oc_add(word_sum, item.port), item.msg_number);
        computed  = ~full_sum;
        port_idx  = item.port - 16'd1;
        in_range  = (item.port != 16'd0) && (item.port <= 16'(PORTS));
        port_open = in_range && open_mask[port_idx[3:0]];

        result.computed_checksum = computed;
        result.dest_port         = item.port;
        if (computed != item.received_checksum)
        begin
            result.ack_code         = ACK_CSUM_ERR;
            result.forward_checksum = '0;
        end
        else if (!port_open)
        begin
            result.ack_code         = ACK_PORT_CLOSED;
            result.forward_checksum = '0;
        end
        else
        begin
            result.ack_code         = ACK_OK;
            result.forward_checksum = ~word_sum;
        end

        payload_sum_next = payload_sum_reg;
        if (take)
        begin
            payload_sum_next = item.last_word ? '0 : word_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            payload_sum_reg <= '0;
        end
        else
        begin
            payload_sum_reg <= payload_sum_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/frame_checksum_port_router_unit.sv -----
// ============================================================================
// frame_checksum_port_router_unit
// Verifies frame checksums word by word and acknowledges each frame.
// ============================================================================
// Frame words arrive on the frame channel (valid/ready), one 32-bit payload
// word per transfer. The transfer with last_word set also carries the port,
// the message number and the received checksum, and it produces exactly one
// transfer on the result channel with the acknowledge code, the computed
// checksum, the payload-only checksum, zero for a failed frame, and the port.
// A word is accepted into an input register; from there the running sum is
// updated and, for a last word, the result register is loaded. The result is
// presented from the result register. One word is taken every cycle unless a
// last word has to wait for the result register to be free.
// When the receiver stalls, words that are not last keep flowing into the
// sum; a last word waits in the input register until the result register is
// free, and the frame channel then holds ready low.
// Reset clears the running sum, the open-port mask and all valid flags.
// The open-port mask is written through the APB port at address 0.
// ============================================================================
`default_nettype none

module frame_checksum_port_router_unit #(
    parameter int unsigned PORTS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   frame_valid,
    output logic                        frame_ready,
    input  wire fcpr_pkg::frame_item_t  frame,
    output logic                        result_valid,
    input  wire logic                   result_ready,
    output fcpr_pkg::result_item_t      result,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [2:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import fcpr_pkg::*;

    logic             hold_valid;
    frame_item_t      hold;
    logic             take;
    logic             out_free;
    result_item_t     check_result;
    logic [PORTS-1:0] open_ports_reg;
    logic [15:0]      open_mask;
    logic             reg_hit;
    logic             result_valid_reg;
    logic             result_valid_next;
    result_item_t     result_reg;

    assign pready    = 1'b1;
    assign reg_hit   = (paddr[2] == REG_OPEN_PORTS) && (paddr[1:0] == 2'b00);
    assign open_mask = 16'(open_ports_reg);
    assign prdata    = reg_hit ? {16'd0, open_mask} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_ports_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            open_ports_reg <= pwdata[PORTS-1:0];
        end
    end

    assign out_free = !result_valid_reg || result_ready;
    assign take     = hold_valid && (!hold.last_word || out_free);

    fcpr_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame),
        .take        (take),
        .hold_valid  (hold_valid),
        .hold        (hold)
    );

    fcpr_check #(
        .PORTS (PORTS)
    ) u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (hold),
        .take      (take),
        .open_mask (open_mask),
        .result    (check_result)
    );

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (take && hold.last_word)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && hold.last_word)
        begin
            result_reg <= check_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_fwd_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.ack_code != ACK_OK) |-> result.forward_checksum == 16'd0)
        else $error("forward checksum not zero on a failed frame");

    a_ok_port_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.ack_code == ACK_OK)
        |-> (result.dest_port != 16'd0) && (result.dest_port <= 16'(PORTS)))
        else $error("frame acknowledged ok on a port out of range");

    a_accept_fills_hold: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_ready |=> hold_valid)
        else $error("accepted transfer not held in the input register");

    a_last_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        take && hold.last_word |-> out_free)
        else $error("result register overwritten while occupied");

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb
// Testbench of the frame checksum port router unit.
// ============================================================================
// Frames are streamed word by word into the unit. Both sides pause at random.
// A predictor in the testbench keeps the running ones'-complement sum and the
// open-port mask. It computes the acknowledge that each last word must
// produce. Every result transfer is compared field by field with the oldest
// expected acknowledge. The port mask is rewritten between test phases, and
// each write is read back.
// ============================================================================

module tb;

    import fcpr_pkg::*;

    localparam int PORTS         = 16;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 8;

    logic         clk   = 1'b0;
    logic         rst_n = 1'b0;
    logic         frame_valid;
    logic         frame_ready;
    frame_item_t  frame;
    logic         result_valid;
    logic         result_ready;
    result_item_t result;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    frame_checksum_port_router_unit #(
        .PORTS(PORTS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_ready  (frame_ready),
        .frame        (frame),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    logic [15:0]  payload_acc;
    logic [15:0]  port_mask_model;
    result_item_t ack_expected[$];
    result_item_t ack_head;
    int           errors      = 0;
    int           words_sent  = 0;
    int           acks_seen   = 0;
    int           n_ok        = 0;
    int           n_csum_err  = 0;
    int           n_closed    = 0;
    int           mask_writes = 0;
    int           cycles      = 0;
    int           rx_hold     = 0;
    bit           tx_gaps_on;
    bit           rx_stalls_on;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [15:0] oc_fold16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        s = {1'b0, s[15:0]} + {16'h0, s[16]};
        return s[15:0];
    endfunction

    function automatic logic [15:0] frame_check_value(input logic [31:0] word,
                                                      input logic [15:0] port,
                                                      input logic [15:0] msg);
        logic [15:0] acc;
        acc = oc_fold16(oc_fold16(payload_acc, word[15:0]), word[31:16]);
        return ~oc_fold16(oc_fold16(acc, port), msg);
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic logic [31:0] rand_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 32'h0000_0000;
        if (r < 16)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] got_v);
        if (got_v !== exp_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
        end
    endfunction

    task automatic absorb_word(input frame_item_t w);
        result_item_t r;
        logic [15:0]  chk;
        logic         port_open;
        chk = frame_check_value(w.data_word, w.port, w.msg_number);
        payload_acc = oc_fold16(oc_fold16(payload_acc, w.data_word[15:0]),
                                w.data_word[31:16]);
        if (w.last_word)
        begin
            port_open = (w.port >= 1) && (w.port <= PORTS) && port_mask_model[w.port - 1];
            r.computed_checksum = chk;
            r.dest_port = w.port;
            if (chk != w.received_checksum)
            begin
                r.ack_code = ACK_CSUM_ERR;
                r.forward_checksum = 16'h0;
            end
            else if (!port_open)
            begin
                r.ack_code = ACK_PORT_CLOSED;
                r.forward_checksum = 16'h0;
            end
            else
            begin
                r.ack_code = ACK_OK;
                r.forward_checksum = ~payload_acc;
            end
            ack_expected.push_back(r);
            payload_acc = 16'h0;
        end
    endtask

    task automatic send_word(input frame_item_t w);
        int gap;
        frame <= w;
        frame_valid <= 1'b1;
        @(posedge clk);
        while (!frame_ready)
            @(posedge clk);
        absorb_word(w);
        words_sent++;
        gap = (tx_gaps_on && $urandom_range(0, 99) < 30) ? gap_len() : 0;
        if (gap > 0)
        begin
            frame_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_body(input logic [31:0] word);
        frame_item_t w;
        w.data_word = word;
        w.last_word = 1'b0;
        w.port = 16'($urandom);
        w.msg_number = 16'($urandom);
        w.received_checksum = 16'($urandom);
        send_word(w);
    endtask

    task automatic send_tail(input logic [31:0] word, input logic [15:0] port,
                             input logic [15:0] msg, input bit bad_csum);
        frame_item_t w;
        w.data_word = word;
        w.last_word = 1'b1;
        w.port = port;
        w.msg_number = msg;
        w.received_checksum = frame_check_value(word, port, msg);
        if (bad_csum)
            w.received_checksum ^= 16'($urandom_range(1, 65535));
        send_word(w);
    endtask

    task automatic wait_idle();
        frame_valid <= 1'b0;
        while (ack_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_port_mask(input logic [15:0] value);
        logic [31:0] rd;
        wait_idle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_OPEN_PORTS, 2'b00};
        pwdata <= {16'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        port_mask_model = value;
        mask_writes++;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        rd = prdata;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (rd[15:0] !== value)
        begin
            errors++;
            $display("%0t: port mask read back, expected %h, got %h", $time, value, rd[15:0]);
        end
    endtask

    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold <= rx_hold - 1;
            result_ready <= 1'b0;
        end
        else if (rx_stalls_on && $urandom_range(0, 99) < 25)
        begin
            rx_hold <= gap_len() - 1;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (ack_expected.size() == 0)
            begin
                errors++;
                $display("%0t: result transfer with none expected, got %h", $time, result);
            end
            else
            begin
                ack_head = ack_expected.pop_front();
                check_field("ack_code", 16'(ack_head.ack_code), 16'(result.ack_code));
                check_field("computed_checksum", ack_head.computed_checksum,
                            result.computed_checksum);
                check_field("forward_checksum", ack_head.forward_checksum,
                            result.forward_checksum);
                check_field("dest_port", ack_head.dest_port, result.dest_port);
                acks_seen++;
                case (ack_head.ack_code)
                    ACK_OK:          n_ok++;
                    ACK_CSUM_ERR:    n_csum_err++;
                    default:         n_closed++;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Header fields before the mask is first written.
    task automatic test_reset_mask();
        send_tail(32'h0000_0000, 16'd0, 16'd0, 1'b0);
        send_tail(32'h0000_0000, 16'd1, 16'd0, 1'b0);
        send_body(32'hFFFF_FFFF);
        send_tail(32'h0000_0001, 16'd16, 16'hFFFF, 1'b0);
    endtask

    task automatic test_corner_frames();
        set_port_mask(16'hFFFF);
        send_tail(32'hFFFF_FFFF, 16'd16, 16'hFFFF, 1'b0);
        send_tail(32'h0001_FFFF, 16'd1, 16'h0000, 1'b0);
        send_tail(32'h0000_0000, 16'd1, 16'hFFFE, 1'b0);
        send_body(32'h1234_5678);
        send_body(32'hFFFF_FFFF);
        send_body(32'h0000_0000);
        send_tail(32'h89AB_CDEF, 16'd8, 16'h1234, 1'b0);
        send_tail(rand_word(), 16'd1, 16'($urandom), 1'b1);
        send_tail(rand_word(), 16'd0, 16'($urandom), 1'b1);
        send_tail(rand_word(), 16'd17, 16'($urandom), 1'b1);
        send_tail(rand_word(), 16'd17, 16'($urandom), 1'b0);
        send_tail(rand_word(), 16'hFFFF, 16'hFFFF, 1'b0);
        set_port_mask(16'h0001);
        send_tail(rand_word(), 16'd1, 16'($urandom), 1'b0);
        send_tail(rand_word(), 16'd2, 16'($urandom), 1'b0);
        send_tail(rand_word(), 16'd16, 16'($urandom), 1'b0);
    endtask

    task automatic test_random_traffic(input logic [15:0] mask, input int n_words,
                                       input bit gaps, input bit stalls);
        int          target;
        int          len;
        int          r;
        logic [15:0] port;
        set_port_mask(mask);
        tx_gaps_on = gaps;
        rx_stalls_on = stalls;
        target = words_sent + n_words;
        while (words_sent < target)
        begin
            len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 40);
            r = $urandom_range(0, 99);
            if (r < 70)
                port = 16'($urandom_range(1, PORTS));
            else if (r < 78)
                port = 16'd0;
            else if (r < 88)
                port = 16'($urandom_range(PORTS + 1, 31));
            else
                port = 16'($urandom);
            repeat (len - 1) send_body(rand_word());
            send_tail(rand_word(), port, 16'($urandom), $urandom_range(0, 99) < 20);
        end
        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;
    endtask

    initial
    begin
        frame_valid <= 1'b0;
        frame <= '0;
        result_ready <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        payload_acc = 16'h0;
        port_mask_model = 16'h0;
        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_mask();
        test_corner_frames();
        test_random_traffic(16'hFFFF, 300, 1'b1, 1'b1);
        test_random_traffic(16'h0000, 150, 1'b1, 1'b1);
        test_random_traffic(16'h8001, 250, 1'b0, 1'b0);
        test_random_traffic(16'($urandom), 350, 1'b1, 1'b1);
        test_random_traffic(16'hAAAA, 300, 1'b1, 1'b0);
        test_random_traffic(16'h5555, 100, 1'b0, 1'b1);

        wait_idle();
        if (ack_expected.size() != 0)
        begin
            errors += ack_expected.size();
            $display("%0t: %0d acknowledges never arrived", $time, ack_expected.size());
        end
        $display("Streamed %0d frame words under %0d port mask settings.", words_sent,
                 mask_writes);
        $display("Checked %0d acknowledges: %0d ok, %0d checksum errors, %0d closed ports.",
                 acks_seen, n_ok, n_csum_err, n_closed);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
